### hdl/tmwf_pkg.sv
// tmwf_pkg: shared types, constants and trim-bound functions for the
// trimmed mean window filter. No dependencies; imported by every module.
package tmwf_pkg;

   // sample and result width
   localparam int DATA_W = 32;
   // reciprocal bits consumed per multiply step
   localparam int RECIP_CHUNK_W = 16;
   // trim percentages
   localparam int PCT_LOW = 15;
   localparam int PCT_HIGH = 85;
   localparam int PCT_DEN = 100;

   // first kept index of the sorted window
   function automatic int tmwf_low_cut(input int win);
      int lo;
      lo = (win * PCT_LOW) / PCT_DEN;
      if (lo < 1) begin
         lo = 1;
      end
      return lo;
   endfunction

   // first discarded index above the kept range
   function automatic int tmwf_high_lim(input int win);
      int hi;
      hi = (win * PCT_HIGH) / PCT_DEN + 1;
      if (hi > win - 1) begin
         hi = win - 1;
      end
      return hi;
   endfunction

   // number of kept entries, the divisor of the mean
   function automatic int tmwf_kept_count(input int win);
      return tmwf_high_lim(win) - tmwf_low_cut(win);
   endfunction

   // multiply steps to apply the reciprocal of the kept count
   function automatic int tmwf_mul_cycles(input int win);
      int mag_w;
      mag_w = DATA_W + $clog2(tmwf_kept_count(win));
      return (mag_w + RECIP_CHUNK_W) / RECIP_CHUNK_W;
   endfunction

   // controller to datapath commands
   typedef struct packed {
      logic load;        // write beat into ring and copy window to sorter
      logic sort_en;     // one odd-even transposition pass
      logic sort_phase;  // 0: pairs start even, 1: pairs start odd
      logic sum_en;      // shift sorted copy down by one
      logic add_en;      // accumulate the entry leaving the bottom
      logic div_init;    // take magnitude and sign of the sum
      logic div_en;      // one reciprocal multiply step
      logic publish;     // load output register
   } tmwf_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_busy;    // output register holds a beat that is not taken
   } tmwf_status_type;

endpackage

### hdl/trimmed_mean_window_filter.sv
// trimmed_mean_window_filter: top level joining controller and datapath.
// Depends on tmwf_pkg, tmwf_ctrl and tmwf_datapath.
//
// Usage:
//   req channel: valid/ready, one 32-bit signed sample per beat. Each sample
//   replaces the oldest entry of a ring window of WINDOW samples.
//   rsp channel: valid/ready, one 32-bit signed trimmed mean per request:
//   the window is sorted, the lowest and highest entries are dropped and the
//   rest averaged, truncating toward zero.
//   From accept to rsp_valid the filter runs the sort passes, the sum shifts
//   up to the last kept index, a divider setup step, the reciprocal
//   multiply steps and a publish step, one phase after another.
//   A new sample is taken only once the previous one has been published;
//   the pace is set by the odd-even transposition sorter, the one-entry-per-
//   cycle accumulator and the 16-bit-per-step reciprocal multiply.
//   The output register frees the input side: a new sample is taken while a
//   result still waits. If the receiver stalls, the next result waits in the
//   final state until the output register is free.
//   Reset (synchronous, active high) clears the window to zeros, the slot
//   pointer to zero and drops any pending result.
module trimmed_mean_window_filter import tmwf_pkg::*; #(
   parameter int WINDOW = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_filtered
);

   tmwf_cmd_type    cmd;
   tmwf_status_type status;

   // sequencer
   tmwf_ctrl #(
      .WINDOW(WINDOW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // window, sorter, divider and output register
   tmwf_datapath #(
      .WINDOW(WINDOW)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_filtered (rsp_filtered)
   );

endmodule

### hdl/tmwf_ctrl.sv
// tmwf_ctrl: sequencer for load, sort, sum, divide and publish phases.
// Depends on tmwf_pkg for command and status types and trim bounds.
module tmwf_ctrl import tmwf_pkg::*; #(
   parameter int WINDOW = 5
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  tmwf_status_type status,
   output tmwf_cmd_type    cmd
);

   localparam int LO_CUT   = tmwf_low_cut(WINDOW);
   localparam int HI_LIM   = tmwf_high_lim(WINDOW);
   localparam int DIV_CYC  = tmwf_mul_cycles(WINDOW);
   localparam int CNT_MAX  = (WINDOW > DIV_CYC) ? WINDOW : DIV_CYC;
   localparam int CNT_W    = $clog2(CNT_MAX + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SORT = 3'd1;
   localparam logic [2:0] ST_SUM  = 3'd2;
   localparam logic [2:0] ST_PREP = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in = '0;
               state_in = ST_SORT;
            end
         end
         ST_SORT: begin
            cmd.sort_en = 1'b1;
            cmd.sort_phase = cnt_ff[0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(WINDOW - 1)) begin
               cnt_in = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            cmd.add_en = (cnt_ff >= CNT_W'(LO_CUT)) && (cnt_ff < CNT_W'(HI_LIM));
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(HI_LIM - 1)) begin
               cnt_in = '0;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.div_init = 1'b1;
            cnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_en = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_CYC - 1)) begin
               cnt_in = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.publish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   // an accepted beat always starts the sort phase
   a_accept_sorts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_SORT)
      else $error("accepted beat did not start sorting");

   // never overwrite a result still waiting at the output
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !status.out_busy)
      else $error("publish while output register busy");

   // pass counter stays within the window during sorting
   a_sort_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SORT |-> cnt_ff < CNT_W'(WINDOW))
      else $error("sort pass counter out of range");

endmodule

### hdl/tmwf_datapath.sv
// tmwf_datapath: ring window, transposition sorter, accumulator,
// reciprocal multiply divider and output register. Depends on tmwf_pkg.
module tmwf_datapath import tmwf_pkg::*; #(
   parameter int WINDOW = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tmwf_cmd_type             cmd,
   output tmwf_status_type          status,
   input  logic signed [DATA_W-1:0] req_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_filtered
);

   localparam int CUT_CNT = tmwf_kept_count(WINDOW);
   localparam int CUT_LOG = $clog2(CUT_CNT);
   localparam int PTR_W   = $clog2(WINDOW);
   localparam int SUM_W   = DATA_W + 1 + $clog2(WINDOW);
   localparam int MAG_W   = DATA_W + CUT_LOG;
   localparam int MUL_CYC = tmwf_mul_cycles(WINDOW);
   localparam int REC_W   = MUL_CYC * RECIP_CHUNK_W;
   localparam int REC_SH  = MAG_W + CUT_LOG;
   localparam int PROD_W  = MAG_W + RECIP_CHUNK_W;
   localparam int Q_SH    = REC_SH - (MUL_CYC - 1) * RECIP_CHUNK_W;
   // ceil(2^REC_SH / kept count), exact floor quotient for any magnitude
   localparam logic [63:0] REC_FULL =
      ((64'd1 << REC_SH) + 64'(CUT_CNT) - 64'd1) / 64'(CUT_CNT);
   localparam logic [REC_W-1:0] RECIP = REC_W'(REC_FULL);

   logic signed [DATA_W-1:0] win_ff [WINDOW];
   logic signed [DATA_W-1:0] sort_ff [WINDOW];
   logic signed [DATA_W-1:0] sort_in [WINDOW];
   logic [PTR_W-1:0]         ptr_ff;
   logic [PTR_W-1:0]         ptr_in;
   logic signed [SUM_W-1:0]  acc_ff;
   logic [SUM_W-1:0]         acc_abs;
   logic [MAG_W-1:0]         mag_ff;
   logic [REC_W-1:0]         rec_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic [PROD_W-1:0]        part;
   logic                     neg_ff;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_filtered_ff;
   logic [DATA_W-1:0]        quot;

   // next ring slot
   assign ptr_in = (ptr_ff == PTR_W'(WINDOW - 1)) ? '0 : ptr_ff + 1'b1;

   // sorter copy: load, compare-exchange pass or shift-down
   always_comb begin
      sort_in = sort_ff;
      if (cmd.load) begin
         for (int i = 0; i < WINDOW; i++) begin
            sort_in[i] = (PTR_W'(i) == ptr_in) ? req_sample : win_ff[i];
         end
      end else if (cmd.sort_en) begin
         for (int i = 0; i < WINDOW - 1; i++) begin
            if ((i % 2) == int'(cmd.sort_phase) && sort_ff[i] > sort_ff[i + 1]) begin
               sort_in[i] = sort_ff[i + 1];
               sort_in[i + 1] = sort_ff[i];
            end
         end
      end else if (cmd.sum_en) begin
         for (int i = 0; i < WINDOW - 1; i++) begin
            sort_in[i] = sort_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      sort_ff <= sort_in;
   end

   // ring window and slot pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         for (int i = 0; i < WINDOW; i++) begin
            win_ff[i] <= '0;
         end
      end else if (cmd.load) begin
         ptr_ff <= ptr_in;
         win_ff[ptr_in] <= req_sample;
      end
   end

   // accumulate kept entries as they leave the bottom of the sorter
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff <= '0;
      end else if (cmd.sum_en && cmd.add_en) begin
         acc_ff <= acc_ff + {{(SUM_W - DATA_W){sort_ff[0][DATA_W-1]}}, sort_ff[0]};
      end
   end

   assign acc_abs = acc_ff[SUM_W-1] ? (~acc_ff + 1'b1) : acc_ff;

   // magnitude times one 16-bit slice of the reciprocal
   assign part = PROD_W'(mag_ff) * PROD_W'(rec_ff[RECIP_CHUNK_W-1:0]);

   // multiply by the reciprocal low slice first, dropping settled low bits
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         neg_ff <= acc_ff[SUM_W-1];
         mag_ff <= MAG_W'(acc_abs);
         rec_ff <= RECIP;
         prod_ff <= '0;
      end else if (cmd.div_en) begin
         rec_ff <= rec_ff >> RECIP_CHUNK_W;
         prod_ff <= (prod_ff >> RECIP_CHUNK_W) + part;
      end
   end

   // output register, quotient rounds toward zero
   assign quot = prod_ff[Q_SH +: DATA_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_filtered_ff <= neg_ff ? -$signed(quot) : $signed(quot);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

   // a published result shows up as a valid beat next cycle
   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid_ff)
      else $error("published result not presented");

   // the window only changes on a load command, checked through its slot pointer
   a_window_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.load |=> $stable(ptr_ff))
      else $error("slot pointer moved without a load");

   // sort passes never overlap a load, a sum shift or a divide step
   a_phase_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.sort_en && (cmd.div_en || cmd.sum_en || cmd.load)))
      else $error("overlapping datapath commands");

endmodule

### sim/trimmed_mean_monitor.sv
`timescale 1ns / 1ps
// trimmed_mean_monitor: watches the req and rsp channels of the trimmed mean
// window filter, predicts each mean from its own copy of the ring window and
// compares. Depends on tmwf_pkg for the data width.
module trimmed_mean_monitor import tmwf_pkg::*; #(
   parameter int WINDOW = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_sample,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic signed [DATA_W-1:0] rsp_filtered,
   output int                       mismatch_count,
   output int                       pending_count
);

   // trim bounds in percent: share dropped at the low end, upper edge of the kept range
   localparam int DROP_LOW_PCT  = 15;
   localparam int KEEP_HIGH_PCT = 85;
   localparam int PCT_SCALE     = 100;

   logic signed [DATA_W-1:0] window_slots [WINDOW];
   int                       write_slot;
   logic signed [DATA_W-1:0] pending_means [$];
   int                       error_total;

   assign mismatch_count = error_total;

   // sort a copy of the window, drop both ends, average the rest toward zero
   function automatic logic signed [DATA_W-1:0] trimmed_mean();
      logic signed [DATA_W-1:0] ordered [WINDOW];
      logic signed [DATA_W-1:0] key;
      longint                   total;
      int                       i;
      int                       j;
      int                       first_kept;
      int                       past_kept;
      int                       kept;
      for (i = 0; i < WINDOW; i++) begin
         ordered[i] = window_slots[i];
      end
      for (i = 1; i < WINDOW; i++) begin
         key = ordered[i];
         j = i - 1;
         while (j >= 0 && ordered[j] > key) begin
            ordered[j + 1] = ordered[j];
            j--;
         end
         ordered[j + 1] = key;
      end
      first_kept = (WINDOW * DROP_LOW_PCT) / PCT_SCALE;
      if (first_kept < 1) begin
         first_kept = 1;
      end
      past_kept = (WINDOW * KEEP_HIGH_PCT) / PCT_SCALE + 1;
      if (past_kept > WINDOW - 1) begin
         past_kept = WINDOW - 1;
      end
      total = 0;
      kept = 0;
      for (i = first_kept; i < past_kept; i++) begin
         total += longint'(ordered[i]);
         kept++;
      end
      if (kept == 0) begin
         return '0;
      end
      return DATA_W'(total / longint'(kept));
   endfunction

   // one line per mismatch
   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      error_total++;
   endtask

   initial begin
      error_total = 0;
      pending_count = 0;
      write_slot = 0;
   end

   always @(posedge clock) begin
      logic signed [DATA_W-1:0] wanted;
      if (reset) begin
         // window cleared to zeros, pointer back to slot zero
         for (int i = 0; i < WINDOW; i++) begin
            window_slots[i] = '0;
         end
         write_slot = 0;
         pending_means.delete();
      end else begin
         // result beat against the oldest predicted mean
         if (rsp_valid && rsp_ready) begin
            if (pending_means.size() == 0) begin
               report_mismatch($sformatf("result %0d with no mean pending", rsp_filtered));
            end else begin
               wanted = pending_means.pop_front();
               if (rsp_filtered !== wanted) begin
                  report_mismatch($sformatf("filtered got %0d want %0d",
                                            rsp_filtered, wanted));
               end
            end
         end
         // sample beat: advance pointer, then write, then predict
         if (req_valid && req_ready) begin
            write_slot = (write_slot + 1) % WINDOW;
            window_slots[write_slot] = req_sample;
            pending_means.push_back(trimmed_mean());
         end
      end
      pending_count <= pending_means.size();
   end

endmodule

### sim/trimmed_mean_window_filter_tb.sv
`timescale 1ns / 1ps
// trimmed_mean_window_filter_tb: drives samples into the filter with random
// gaps and stalls and gives the verdict. Depends on tmwf_pkg, the filter
// and trimmed_mean_monitor.
module trimmed_mean_window_filter_tb;
   import tmwf_pkg::*;

   localparam int WINDOW       = 5;
   localparam int RANDOM_BEATS = 1200;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_GAP      = 11;

   typedef enum int {
      KIND_FULL,
      KIND_SMALL,
      KIND_NEAR_MAX,
      KIND_NEAR_MIN,
      KIND_REPEAT
   } sample_kind_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic signed [DATA_W-1:0] req_sample;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [DATA_W-1:0] rsp_filtered;
   int                       mismatch_count;
   int                       pending_count;
   int                       cycle_count;
   int                       req_gap_max;
   int                       rsp_gap_max;
   logic signed [DATA_W-1:0] last_sample;

   localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7FFFFFFF;
   localparam logic signed [DATA_W-1:0] S_MIN = 32'sh80000000;

   // extremes, sign edges, zeros left over after reset, truncation of a
   // negative sum toward zero
   logic signed [DATA_W-1:0] directed_samples [$] = '{
      32'sd1, -32'sd1,
      S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
      S_MIN, S_MIN, S_MIN, S_MIN, S_MIN,
      S_MAX, S_MIN, S_MAX, S_MIN, 32'sd0,
      -32'sd1, -32'sd1, 32'sd0, 32'sd0, 32'sd0,
      32'sd12345, -32'sd98765
   };

   trimmed_mean_window_filter #(
      .WINDOW(WINDOW)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_filtered(rsp_filtered)
   );

   trimmed_mean_monitor #(
      .WINDOW(WINDOW)
   ) u_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_filtered  (rsp_filtered),
      .mismatch_count(mismatch_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
   end

   always #10 clock = ~clock;

   // run limit
   initial begin
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // one sample beat, after a random gap; valid stays up between back-to-back beats
   task automatic send_sample(input logic signed [DATA_W-1:0] value);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      last_sample = value;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // random sample biased toward extremes and small values
   function automatic logic signed [DATA_W-1:0] random_sample();
      sample_kind_type kind;
      kind = sample_kind_type'($urandom_range(KIND_FULL, KIND_REPEAT));
      case (kind)
         KIND_SMALL: begin
            return DATA_W'(int'($urandom_range(0, 200)) - 100);
         end
         KIND_NEAR_MAX: begin
            return S_MAX - DATA_W'($urandom_range(0, 15));
         end
         KIND_NEAR_MIN: begin
            return S_MIN + DATA_W'($urandom_range(0, 15));
         end
         KIND_REPEAT: begin
            return last_sample;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // gap bound for a stretch of beats: none, light or full
   function automatic int pick_gap_max();
      int choice;
      choice = $urandom_range(0, 2);
      if (choice == 0) begin
         return 0;
      end else if (choice == 1) begin
         return 3;
      end
      return MAX_GAP;
   endfunction

   // receiver: random stall before each result beat
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         gap = $urandom_range(0, rsp_gap_max);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // stimulus and verdict
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      last_sample = '0;
      req_gap_max = MAX_GAP;
      rsp_gap_max = MAX_GAP;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_samples[i]) begin
         send_sample(directed_samples[i]);
      end

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 100 == 0) begin
            req_gap_max = pick_gap_max();
            rsp_gap_max = pick_gap_max();
         end
         send_sample(random_sample());
      end
      req_valid <= 1'b0;
      rsp_gap_max = MAX_GAP;

      // drain, then let any stray beat show up
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### files.f
hdl/tmwf_pkg.sv
hdl/tmwf_ctrl.sv
hdl/tmwf_datapath.sv
hdl/trimmed_mean_window_filter.sv
sim/trimmed_mean_monitor.sv
sim/trimmed_mean_window_filter_tb.sv
